// ----- rtl/prl_pkg.sv -----
// Package for the point reflection block: widths, register codes, corner
// reset values and the word type carried through the divider pipeline.
// No dependencies.
package prl_pkg;

  localparam int unsigned CoordW  = 16;  // coordinate and config data width
  localparam int unsigned DiffW   = 17;  // difference of two coordinates
  localparam int unsigned ProdW   = 34;  // product of two differences
  localparam int unsigned DotW    = 35;  // (p-a).d
  localparam int unsigned DdW     = 33;  // d.d, never negative
  localparam int unsigned ProdNW  = 52;  // d * dot
  localparam int unsigned NumW    = 52;  // 2|2 d dot| + d.d, rounding folded in
  localparam int unsigned DenW    = 34;  // 2 d.d
  localparam int unsigned QuotW   = 18;  // rounded quotient magnitude
  localparam int unsigned BaseW   = 18;  // 2a - p
  localparam int unsigned SumW    = 20;  // 2a - p + quotient
  localparam int unsigned CfgIdxW = 2;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [BaseW-1:0]  base_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_X = 2'd0,
    CFG_A_Y = 2'd1,
    CFG_B_X = 2'd2,
    CFG_B_Y = 2'd3
  } cfg_reg_e;

  localparam coord_t CornerAxReset = 16'sd0;
  localparam coord_t CornerAyReset = 16'sd0;
  localparam coord_t CornerBxReset = 16'sd1000;
  localparam coord_t CornerByReset = 16'sd0;

  localparam coord_t CoordMax = 16'sh7fff;
  localparam coord_t CoordMin = 16'sh8000;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
  } corners_t;

  // one word in flight through the restoring divider lanes
  typedef struct packed {
    logic [NumW-1:0]  rem_x;
    logic [NumW-1:0]  rem_y;
    logic [DenW-1:0]  den;
    logic [QuotW-1:0] quo_x;
    logic [QuotW-1:0] quo_y;
    logic             neg_x;
    logic             neg_y;
    base_t            base_x;
    base_t            base_y;
    coord_t           pt_x;
    coord_t           pt_y;
    logic             reflect;
    logic             degen;
  } div_word_t;

endpackage

// ----- rtl/prl_ifs.sv -----
// Valid/ready channel interfaces of the point reflection block: scan point
// input, result output and configuration write. Depends on prl_pkg.
interface prl_in_if;
  logic                   valid;
  logic                   ready;
  logic signed [prl_pkg::CoordW-1:0] point_x;
  logic signed [prl_pkg::CoordW-1:0] point_y;
  logic                   point_present;

  modport source(output valid, output point_x, output point_y, output point_present,
                 input ready);
  modport sink(input valid, input point_x, input point_y, input point_present,
               output ready);
endinterface

interface prl_out_if;
  logic                   valid;
  logic                   ready;
  logic signed [prl_pkg::CoordW-1:0] reflected_x;
  logic signed [prl_pkg::CoordW-1:0] reflected_y;
  logic                   was_reflected;
  logic                   clipped;

  modport source(output valid, output reflected_x, output reflected_y,
                 output was_reflected, output clipped, input ready);
  modport sink(input valid, input reflected_x, input reflected_y,
               input was_reflected, input clipped, output ready);
endinterface

interface prl_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [prl_pkg::CfgIdxW-1:0]   index;
  logic [prl_pkg::CoordW-1:0]    data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/prl_front.sv -----
// Front end of the point reflection pipeline: differences, dot products,
// d.d and the numerator/denominator setup, five register stages.
// Depends on prl_pkg.
module prl_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  prl_pkg::corners_t          corners_i,
  input  logic                       valid_i,
  input  prl_pkg::coord_t            point_x_i,
  input  prl_pkg::coord_t            point_y_i,
  input  logic                       point_present_i,
  output logic                       ready_o,
  output logic                       valid_o,
  output prl_pkg::div_word_t         word_o,
  input  logic                       ready_i
);

  typedef struct packed {
    logic signed [prl_pkg::DiffW-1:0] ex;
    logic signed [prl_pkg::DiffW-1:0] ey;
    logic signed [prl_pkg::DiffW-1:0] dx;
    logic signed [prl_pkg::DiffW-1:0] dy;
    prl_pkg::base_t                   base_x;
    prl_pkg::base_t                   base_y;
    prl_pkg::coord_t                  pt_x;
    prl_pkg::coord_t                  pt_y;
    logic                             live;
  } s1_t;

  typedef struct packed {
    logic signed [prl_pkg::ProdW-1:0] exdx;
    logic signed [prl_pkg::ProdW-1:0] eydy;
    logic signed [prl_pkg::ProdW-1:0] dxdx;
    logic signed [prl_pkg::ProdW-1:0] dydy;
    logic signed [prl_pkg::DiffW-1:0] dx;
    logic signed [prl_pkg::DiffW-1:0] dy;
    prl_pkg::base_t                   base_x;
    prl_pkg::base_t                   base_y;
    prl_pkg::coord_t                  pt_x;
    prl_pkg::coord_t                  pt_y;
    logic                             live;
  } s2_t;

  typedef struct packed {
    logic signed [prl_pkg::DotW-1:0]  dot;
    logic [prl_pkg::DdW-1:0]          dd;
    logic signed [prl_pkg::DiffW-1:0] dx;
    logic signed [prl_pkg::DiffW-1:0] dy;
    prl_pkg::base_t                   base_x;
    prl_pkg::base_t                   base_y;
    prl_pkg::coord_t                  pt_x;
    prl_pkg::coord_t                  pt_y;
    logic                             live;
  } s3_t;

  typedef struct packed {
    logic signed [prl_pkg::ProdNW-1:0] nx;
    logic signed [prl_pkg::ProdNW-1:0] ny;
    logic [prl_pkg::DdW-1:0]           dd;
    prl_pkg::base_t                    base_x;
    prl_pkg::base_t                    base_y;
    prl_pkg::coord_t                   pt_x;
    prl_pkg::coord_t                   pt_y;
    logic                              live;
  } s4_t;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  prl_pkg::div_word_t s5_d, s5_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // a stage loads when it is empty or its word moves on this cycle
  assign rdy5    = !v5_q || ready_i;
  assign rdy4    = !v4_q || rdy5;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v5_q;
  assign word_o  = s5_q;

  // stage 1: differences and 2a - p
  always_comb begin
    logic signed [prl_pkg::DiffW-1:0] px_w, py_w, ax_w, ay_w, bx_w, by_w;
    logic signed [prl_pkg::BaseW-1:0] ax_b, ay_b, px_b, py_b;
    px_w = prl_pkg::DiffW'(point_x_i);
    py_w = prl_pkg::DiffW'(point_y_i);
    ax_w = prl_pkg::DiffW'(corners_i.ax);
    ay_w = prl_pkg::DiffW'(corners_i.ay);
    bx_w = prl_pkg::DiffW'(corners_i.bx);
    by_w = prl_pkg::DiffW'(corners_i.by);
    ax_b = prl_pkg::BaseW'(corners_i.ax);
    ay_b = prl_pkg::BaseW'(corners_i.ay);
    px_b = prl_pkg::BaseW'(point_x_i);
    py_b = prl_pkg::BaseW'(point_y_i);
    s1_d.ex     = px_w - ax_w;
    s1_d.ey     = py_w - ay_w;
    s1_d.dx     = bx_w - ax_w;
    s1_d.dy     = by_w - ay_w;
    s1_d.base_x = (ax_b <<< 1) - px_b;
    s1_d.base_y = (ay_b <<< 1) - py_b;
    s1_d.pt_x   = point_x_i;
    s1_d.pt_y   = point_y_i;
    s1_d.live   = point_present_i && (point_x_i != '0) && (point_y_i != '0);
  end

  // stage 2: the four 17x17 products
  always_comb begin
    s2_d.exdx   = s1_q.ex * s1_q.dx;
    s2_d.eydy   = s1_q.ey * s1_q.dy;
    s2_d.dxdx   = s1_q.dx * s1_q.dx;
    s2_d.dydy   = s1_q.dy * s1_q.dy;
    s2_d.dx     = s1_q.dx;
    s2_d.dy     = s1_q.dy;
    s2_d.base_x = s1_q.base_x;
    s2_d.base_y = s1_q.base_y;
    s2_d.pt_x   = s1_q.pt_x;
    s2_d.pt_y   = s1_q.pt_y;
    s2_d.live   = s1_q.live;
  end

  // stage 3: dot product and d.d
  always_comb begin
    logic signed [prl_pkg::ProdW-1:0] dd_s;
    dd_s        = s2_q.dxdx + s2_q.dydy;
    s3_d.dot    = prl_pkg::DotW'(s2_q.exdx) + prl_pkg::DotW'(s2_q.eydy);
    s3_d.dd     = prl_pkg::DdW'(dd_s);
    s3_d.dx     = s2_q.dx;
    s3_d.dy     = s2_q.dy;
    s3_d.base_x = s2_q.base_x;
    s3_d.base_y = s2_q.base_y;
    s3_d.pt_x   = s2_q.pt_x;
    s3_d.pt_y   = s2_q.pt_y;
    s3_d.live   = s2_q.live;
  end

  // stage 4: d * dot, 17x35 per lane
  always_comb begin
    s4_d.nx     = s3_q.dx * s3_q.dot;
    s4_d.ny     = s3_q.dy * s3_q.dot;
    s4_d.dd     = s3_q.dd;
    s4_d.base_x = s3_q.base_x;
    s4_d.base_y = s3_q.base_y;
    s4_d.pt_x   = s3_q.pt_x;
    s4_d.pt_y   = s3_q.pt_y;
    s4_d.live   = s3_q.live;
  end

  // stage 5: round to nearest by dividing (2|2 d dot| + dd) by 2 dd
  always_comb begin
    logic [prl_pkg::ProdNW-1:0] abs_x, abs_y;
    logic                       dd_zero;
    abs_x   = s4_q.nx[prl_pkg::ProdNW-1] ? prl_pkg::ProdNW'(-s4_q.nx)
                                         : prl_pkg::ProdNW'(s4_q.nx);
    abs_y   = s4_q.ny[prl_pkg::ProdNW-1] ? prl_pkg::ProdNW'(-s4_q.ny)
                                         : prl_pkg::ProdNW'(s4_q.ny);
    dd_zero = (s4_q.dd == '0);
    s5_d.rem_x   = prl_pkg::NumW'({abs_x, 2'b00}) + prl_pkg::NumW'(s4_q.dd);
    s5_d.rem_y   = prl_pkg::NumW'({abs_y, 2'b00}) + prl_pkg::NumW'(s4_q.dd);
    s5_d.den     = prl_pkg::DenW'({s4_q.dd, 1'b0});
    s5_d.quo_x   = '0;
    s5_d.quo_y   = '0;
    s5_d.neg_x   = s4_q.nx[prl_pkg::ProdNW-1];
    s5_d.neg_y   = s4_q.ny[prl_pkg::ProdNW-1];
    s5_d.base_x  = s4_q.base_x;
    s5_d.base_y  = s4_q.base_y;
    s5_d.pt_x    = s4_q.pt_x;
    s5_d.pt_y    = s4_q.pt_y;
    s5_d.reflect = s4_q.live && !dd_zero;
    s5_d.degen   = s4_q.live && dd_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) s1_q <= s1_d;
    if (rdy2 && v1_q)    s2_q <= s2_d;
    if (rdy3 && v2_q)    s3_q <= s3_d;
    if (rdy4 && v3_q)    s4_q <= s4_d;
    if (rdy5 && v4_q)    s5_q <= s5_d;
  end

endmodule

// ----- rtl/prl_div_stage.sv -----
// One restoring-division step for both lanes (x and y) with its register
// and valid bit. Resolves quotient bit Bit. Depends on prl_pkg.
module prl_div_stage #(
  parameter int unsigned Bit = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  prl_pkg::div_word_t word_i,
  output logic               ready_o,
  output logic               valid_o,
  output prl_pkg::div_word_t word_o,
  input  logic               ready_i
);

  prl_pkg::div_word_t word_d, word_q;
  logic               valid_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    logic [prl_pkg::NumW-1:0] trial;
    trial  = prl_pkg::NumW'(word_i.den) << Bit;
    word_d = word_i;
    if (word_i.rem_x >= trial) begin
      word_d.rem_x      = word_i.rem_x - trial;
      word_d.quo_x[Bit] = 1'b1;
    end
    if (word_i.rem_y >= trial) begin
      word_d.rem_y      = word_i.rem_y - trial;
      word_d.quo_y[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) word_q <= word_d;
  end

endmodule

// ----- rtl/prl_back.sv -----
// Back end of the point reflection pipeline: signs the quotients, adds
// 2a - p, saturates to 16 bits and holds the result word. Depends on prl_pkg.
module prl_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  prl_pkg::div_word_t word_i,
  output logic               ready_o,
  output logic               valid_o,
  output prl_pkg::coord_t    reflected_x_o,
  output prl_pkg::coord_t    reflected_y_o,
  output logic               was_reflected_o,
  output logic               clipped_o,
  input  logic               ready_i
);

  localparam int unsigned QuotSW = prl_pkg::QuotW + 1;

  prl_pkg::coord_t rx_d, ry_d, rx_q, ry_q;
  logic            refl_d, clip_d, refl_q, clip_q;
  logic            valid_q;

  assign ready_o         = !valid_q || ready_i;
  assign valid_o         = valid_q;
  assign reflected_x_o   = rx_q;
  assign reflected_y_o   = ry_q;
  assign was_reflected_o = refl_q;
  assign clipped_o       = clip_q;

  always_comb begin
    logic signed [QuotSW-1:0]        qx, qy;
    logic signed [prl_pkg::SumW-1:0] sx, sy;
    logic                            sat_x, sat_y;
    prl_pkg::coord_t                 cx, cy;
    qx = word_i.neg_x ? -$signed({1'b0, word_i.quo_x}) : $signed({1'b0, word_i.quo_x});
    qy = word_i.neg_y ? -$signed({1'b0, word_i.quo_y}) : $signed({1'b0, word_i.quo_y});
    sx = prl_pkg::SumW'(word_i.base_x) + prl_pkg::SumW'(qx);
    sy = prl_pkg::SumW'(word_i.base_y) + prl_pkg::SumW'(qy);
    sat_x = 1'b0;
    sat_y = 1'b0;
    if (sx > prl_pkg::SumW'(prl_pkg::CoordMax)) begin
      cx    = prl_pkg::CoordMax;
      sat_x = 1'b1;
    end else if (sx < prl_pkg::SumW'(prl_pkg::CoordMin)) begin
      cx    = prl_pkg::CoordMin;
      sat_x = 1'b1;
    end else begin
      cx = prl_pkg::CoordW'(sx);
    end
    if (sy > prl_pkg::SumW'(prl_pkg::CoordMax)) begin
      cy    = prl_pkg::CoordMax;
      sat_y = 1'b1;
    end else if (sy < prl_pkg::SumW'(prl_pkg::CoordMin)) begin
      cy    = prl_pkg::CoordMin;
      sat_y = 1'b1;
    end else begin
      cy = prl_pkg::CoordW'(sy);
    end
    if (word_i.reflect) begin
      rx_d   = cx;
      ry_d   = cy;
      refl_d = 1'b1;
      clip_d = sat_x || sat_y;
    end else begin
      // passed through; corners coinciding still flag clipped
      rx_d   = word_i.pt_x;
      ry_d   = word_i.pt_y;
      refl_d = 1'b0;
      clip_d = word_i.degen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rx_q   <= rx_d;
      ry_q   <= ry_d;
      refl_q <= refl_d;
      clip_q <= clip_d;
    end
  end

endmodule

// ----- rtl/point_reflection_across_line.sv -----
// Point reflection across the line through two configured corners.
// An accepted point passes 5 front stages, 18 divider stages and 1 output
// stage to its result word. Throughput: one word per cycle unless the output
// stalls; the 18-step restoring divider in both lanes sets the depth.
// Reset clears all valid bits and loads corner a = (0, 0), corner b = (1000, 0).
// Depends on prl_pkg, prl_ifs, prl_front, prl_div_stage, prl_back.
module point_reflection_across_line (
  input  logic      clk_i,
  input  logic      rst_ni,
  prl_in_if.sink    point_i,
  prl_out_if.source result_o,
  prl_cfg_if.sink   cfg_i
);

  localparam int unsigned NStages = prl_pkg::QuotW;

  prl_pkg::corners_t  corners_q;
  prl_pkg::div_word_t div_w [NStages+1];
  logic               div_v [NStages+1];
  logic               div_rdy [NStages+1];

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corners_q.ax <= prl_pkg::CornerAxReset;
      corners_q.ay <= prl_pkg::CornerAyReset;
      corners_q.bx <= prl_pkg::CornerBxReset;
      corners_q.by <= prl_pkg::CornerByReset;
    end else if (cfg_i.valid) begin
      case (prl_pkg::cfg_reg_e'(cfg_i.index))
        prl_pkg::CFG_A_X: corners_q.ax <= cfg_i.data;
        prl_pkg::CFG_A_Y: corners_q.ay <= cfg_i.data;
        prl_pkg::CFG_B_X: corners_q.bx <= cfg_i.data;
        prl_pkg::CFG_B_Y: corners_q.by <= cfg_i.data;
        default: ;
      endcase
    end
  end

  prl_front u_front (
    .clk_i,
    .rst_ni,
    .corners_i       (corners_q),
    .valid_i         (point_i.valid),
    .point_x_i       (point_i.point_x),
    .point_y_i       (point_i.point_y),
    .point_present_i (point_i.point_present),
    .ready_o         (point_i.ready),
    .valid_o         (div_v[0]),
    .word_o          (div_w[0]),
    .ready_i         (div_rdy[0])
  );

  for (genvar i = 0; i < NStages; i++) begin : g_div
    prl_div_stage #(
      .Bit (NStages - 1 - i)
    ) u_stage (
      .clk_i,
      .rst_ni,
      .valid_i (div_v[i]),
      .word_i  (div_w[i]),
      .ready_o (div_rdy[i]),
      .valid_o (div_v[i+1]),
      .word_o  (div_w[i+1]),
      .ready_i (div_rdy[i+1])
    );
  end

  prl_back u_back (
    .clk_i,
    .rst_ni,
    .valid_i         (div_v[NStages]),
    .word_i          (div_w[NStages]),
    .ready_o         (div_rdy[NStages]),
    .valid_o         (result_o.valid),
    .reflected_x_o   (result_o.reflected_x),
    .reflected_y_o   (result_o.reflected_y),
    .was_reflected_o (result_o.was_reflected),
    .clipped_o       (result_o.clipped),
    .ready_i         (result_o.ready)
  );

  // the restoring divider leaves a remainder below the divisor
  a_div_rem_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[NStages] |-> (div_w[NStages].den == '0) ||
      (div_w[NStages].rem_x < prl_pkg::NumW'(div_w[NStages].den)))
    else $error("x remainder not below divisor");

  a_div_rem_y : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[NStages] |-> (div_w[NStages].den == '0) ||
      (div_w[NStages].rem_y < prl_pkg::NumW'(div_w[NStages].den)))
    else $error("y remainder not below divisor");

  // backpressure at the input can only come from a stalled, full output
  a_stall_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_i.ready |-> result_o.valid && !result_o.ready)
    else $error("input stalled without output stall");

  // a word leaving the divider while the output is free shows up next cycle
  a_out_follow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_v[NStages] && div_rdy[NStages] |=> result_o.valid)
    else $error("divider word lost before output");

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for point_reflection_across_line: directed and random scan
// points over several mirror corner settings and handshake patterns.
// Depends on prl_pkg, prl_ifs and the RTL of the block.
module testbench;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PointsPerPhase = 100;

  typedef struct packed {
    prl_pkg::coord_t x;
    prl_pkg::coord_t y;
    logic            present;
  } scan_point_t;

  typedef struct packed {
    prl_pkg::coord_t x;
    prl_pkg::coord_t y;
    logic            reflected;
    logic            clipped;
  } reflection_t;

  logic clk_i;
  logic rst_ni;

  prl_in_if  point_if ();
  prl_out_if result_if ();
  prl_cfg_if cfg_if ();

  point_reflection_across_line DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .point_i  (point_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  // mirror corners as the block should hold them
  prl_pkg::coord_t mirror_ax = prl_pkg::CornerAxReset;
  prl_pkg::coord_t mirror_ay = prl_pkg::CornerAyReset;
  prl_pkg::coord_t mirror_bx = prl_pkg::CornerBxReset;
  prl_pkg::coord_t mirror_by = prl_pkg::CornerByReset;

  scan_point_t pending_points[$];
  reflection_t expected_reflections[$];
  int          points_owed = 0;
  int          mismatches = 0;
  int          mirrored_seen = 0;
  int          clipped_seen = 0;
  int          passed_seen = 0;
  int          settings_run = 1;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned cycle_count = 0;
  logic        point_taken = 1'b0;

  // a set of fixed corner pairs: ax, ay, bx, by
  prl_pkg::coord_t corner_plan [7][4] = '{
    '{16'sd0, -16'sd500, 16'sd0, 16'sd700},          // vertical line
    '{-16'sd1000, -16'sd1000, 16'sd2000, 16'sd2000}, // diagonal
    '{prl_pkg::CoordMin, prl_pkg::CoordMin, prl_pkg::CoordMax, prl_pkg::CoordMax},
    '{prl_pkg::CoordMax, prl_pkg::CoordMin, prl_pkg::CoordMin, prl_pkg::CoordMax},
    '{16'sd123, -16'sd456, 16'sd123, -16'sd456},     // corners coincide
    '{16'sd0, 16'sd0, 16'sd1, 16'sd0},               // shortest direction
    '{prl_pkg::CoordMin, prl_pkg::CoordMax, prl_pkg::CoordMin, prl_pkg::CoordMin}
  };

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ties away from zero; den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic prl_pkg::coord_t saturate(longint v, inout logic hit);
    if (v > prl_pkg::CoordMax) begin
      hit = 1'b1;
      return prl_pkg::CoordMax;
    end
    if (v < prl_pkg::CoordMin) begin
      hit = 1'b1;
      return prl_pkg::CoordMin;
    end
    return prl_pkg::coord_t'(v);
  endfunction

  function automatic reflection_t predict_reflection(scan_point_t pt);
    longint px, py, ax, ay, dx, dy, dd, dot, qx, qy;
    logic hit;
    reflection_t r;
    r.x = pt.x;
    r.y = pt.y;
    r.reflected = 1'b0;
    r.clipped = 1'b0;
    if (pt.present && pt.x != 0 && pt.y != 0) begin
      px = pt.x;
      py = pt.y;
      ax = mirror_ax;
      ay = mirror_ay;
      dx = longint'(mirror_bx) - ax;
      dy = longint'(mirror_by) - ay;
      dd = dx * dx + dy * dy;
      if (dd == 0) begin
        r.clipped = 1'b1;
      end else begin
        dot = (px - ax) * dx + (py - ay) * dy;
        qx = round_div(2 * dx * dot, dd);
        qy = round_div(2 * dy * dot, dd);
        hit = 1'b0;
        r.x = saturate(2 * ax - px + qx, hit);
        r.y = saturate(2 * ay - py + qy, hit);
        r.reflected = 1'b1;
        r.clipped = hit;
      end
    end
    return r;
  endfunction

  // extremes, small values and zeros show up often
  function automatic prl_pkg::coord_t random_coord();
    case ($urandom_range(7))
      0: return prl_pkg::CoordMin;
      1: return prl_pkg::CoordMax;
      2: return prl_pkg::coord_t'($urandom_range(200)) - 16'sd100;
      3: return '0;
      default: return prl_pkg::coord_t'($urandom);
    endcase
  endfunction

  task automatic check_field(string name, int want, int got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  task automatic queue_point(prl_pkg::coord_t x, prl_pkg::coord_t y, logic present);
    scan_point_t pt;
    pt.x = x;
    pt.y = y;
    pt.present = present;
    pending_points.push_back(pt);
    points_owed++;
  endtask

  task automatic drain();
    while (points_owed != 0) @(negedge clk_i);
  endtask

  task automatic write_corner(prl_pkg::cfg_reg_e idx, prl_pkg::coord_t value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      prl_pkg::CFG_A_X: mirror_ax = value;
      prl_pkg::CFG_A_Y: mirror_ay = value;
      prl_pkg::CFG_B_X: mirror_bx = value;
      prl_pkg::CFG_B_Y: mirror_by = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_corners(prl_pkg::coord_t ax, prl_pkg::coord_t ay,
                             prl_pkg::coord_t bx, prl_pkg::coord_t by);
    write_corner(prl_pkg::CFG_A_X, ax);
    write_corner(prl_pkg::CFG_A_Y, ay);
    write_corner(prl_pkg::CFG_B_X, bx);
    write_corner(prl_pkg::CFG_B_Y, by);
    settings_run++;
  endtask

  task automatic run_random_points(int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 82; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 82; end
      default: begin sender_idle_pct = 14; receiver_stall_pct = 14; end
    endcase
    for (int n = 0; n < PointsPerPhase; n++) begin
      queue_point(random_coord(), random_coord(), $urandom_range(9) != 0);
    end
    drain();
  endtask

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk_i) begin : driver
    scan_point_t pt;
    if (rst_ni) begin
      result_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (!point_if.valid || point_taken) begin
        if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          pt = pending_points.pop_front();
          point_if.valid         <= 1'b1;
          point_if.point_x       <= pt.x;
          point_if.point_y       <= pt.y;
          point_if.point_present <= pt.present;
        end else begin
          point_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    scan_point_t pt;
    reflection_t want;
    if (rst_ni) begin
      point_taken <= point_if.valid && point_if.ready;
      if (point_if.valid && point_if.ready) begin
        pt.x = point_if.point_x;
        pt.y = point_if.point_y;
        pt.present = point_if.point_present;
        expected_reflections.push_back(predict_reflection(pt));
      end
      if (result_if.valid && result_if.ready) begin
        if (expected_reflections.size() == 0) begin
          mismatches++;
          $display("%0t: result word with nothing expected, expected none, got x=%0d y=%0d",
                   $time, result_if.reflected_x, result_if.reflected_y);
        end else begin
          want = expected_reflections.pop_front();
          check_field("reflected_x", int'(want.x), int'(result_if.reflected_x));
          check_field("reflected_y", int'(want.y), int'(result_if.reflected_y));
          check_field("was_reflected", int'(want.reflected), int'(result_if.was_reflected));
          check_field("clipped", int'(want.clipped), int'(result_if.clipped));
          if (want.reflected) mirrored_seen++;
          else passed_seen++;
          if (want.clipped) clipped_seen++;
          points_owed--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL point_reflection_across_line");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    point_if.valid = 1'b0;
    point_if.point_x = '0;
    point_if.point_y = '0;
    point_if.point_present = 1'b0;
    result_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset corners: mirror across the x axis
    queue_point(16'sd1, 16'sd1, 1'b1);
    queue_point(prl_pkg::CoordMax, prl_pkg::CoordMax, 1'b1);
    queue_point(prl_pkg::CoordMin, prl_pkg::CoordMin, 1'b1);   // y flips past the top bound
    queue_point(prl_pkg::CoordMax, prl_pkg::CoordMin, 1'b1);
    queue_point(prl_pkg::CoordMin, prl_pkg::CoordMax, 1'b1);
    queue_point(-16'sd1, -16'sd1, 1'b1);
    queue_point(16'sd1, -16'sd1, 1'b1);
    queue_point(16'sd0, 16'sd5, 1'b1);       // zero x passes through
    queue_point(16'sd5, 16'sd0, 1'b1);       // zero y passes through
    queue_point(16'sd0, 16'sd0, 1'b1);
    queue_point(16'sd100, 16'sd200, 1'b0);   // missing point
    queue_point(prl_pkg::CoordMin, prl_pkg::CoordMin, 1'b0);
    queue_point(prl_pkg::CoordMax, prl_pkg::CoordMax, 1'b0);
    queue_point(16'sd1234, -16'sd4321, 1'b1);
    drain();

    // coinciding corners
    set_corners(16'sd77, -16'sd33, 16'sd77, -16'sd33);
    queue_point(16'sd10, 16'sd20, 1'b1);
    queue_point(prl_pkg::CoordMin, prl_pkg::CoordMax, 1'b1);
    queue_point(16'sd0, 16'sd7, 1'b1);
    queue_point(-16'sd5, -16'sd5, 1'b0);
    drain();

    for (int p = 0; p < 7; p++) begin
      set_corners(corner_plan[p][0], corner_plan[p][1], corner_plan[p][2], corner_plan[p][3]);
      run_random_points(p % 4);
    end
    for (int p = 0; p < 4; p++) begin
      set_corners(random_coord(), random_coord(), random_coord(), random_coord());
      run_random_points((p + 3) % 4);
    end

    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    drain();
    repeat (60) @(negedge clk_i);

    $display("Ran %0d corner settings under four handshake patterns.", settings_run);
    $display("Results: %0d mirrored, %0d passed through, %0d clipped or degenerate.",
             mirrored_seen, passed_seen, clipped_seen);
    if (mismatches == 0 && expected_reflections.size() == 0) begin
      $display("PASS point_reflection_across_line");
    end else begin
      $display("FAIL point_reflection_across_line");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/prl_pkg.sv
rtl/prl_ifs.sv
rtl/prl_front.sv
rtl/prl_div_stage.sv
rtl/prl_back.sv
rtl/point_reflection_across_line.sv
test/testbench.sv
